### rtl/brtc_pkg.sv
package brtc_pkg;

    localparam int QUEUE_DEPTH = 2;

    // Clock register numbers
    localparam logic [3:0] REG_SECONDS = 4'd1;
    localparam logic [3:0] REG_MINUTES = 4'd2;
    localparam logic [3:0] REG_HOURS   = 4'd3;
    localparam logic [3:0] REG_DATE    = 4'd5;
    localparam logic [3:0] REG_MONTH   = 4'd6;
    localparam logic [3:0] REG_YEAR    = 4'd7;
    localparam logic [3:0] REG_CONTROL = 4'd8;

    // Calendar snapshot taken at the control byte
    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hour;
        logic [5:0] date;
        logic [3:0] month;
        logic [6:0] year;
        logic       stop;
    } t_snap;

    // Days before the first of the month, non-leap year; mi is month - 1
    function automatic logic [8:0] month_start(input logic [3:0] mi);
        logic [8:0] r;
        case (mi)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd59;
            4'd3:    r = 9'd90;
            4'd4:    r = 9'd120;
            4'd5:    r = 9'd151;
            4'd6:    r = 9'd181;
            4'd7:    r = 9'd212;
            4'd8:    r = 9'd243;
            4'd9:    r = 9'd273;
            4'd10:   r = 9'd304;
            4'd11:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // Month length; mi is month - 1
    function automatic logic [4:0] month_len(input logic [3:0] mi, input logic leap);
        logic [4:0] r;
        case (mi)
            4'd1:                   r = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: r = 5'd30;
            default:                r = 5'd31;
        endcase
        return r;
    endfunction

endpackage

### rtl/bcd_rtc_to_epoch_seconds.sv
// Channel    Direction  Handshake          Payload
// request    in         i_push / o_full    i_register_number, i_register_data
// result     out        o_empty / i_pop    calendar fields, weekday, seconds, slot, stop flag
//
// One request is taken every cycle while o_full is low; no request ever waits on another.
// A control request (register 8) passes, when the result side is drained, into the queue,
// then from queue to day-count stage, then day-count stage to result register.
// Reset is synchronous, active low, and returns the held calendar to 2000-01-01 00:00:00.
// o_full rises only when Q_DEPTH + 2 control snapshots wait because i_pop is held low.
module bcd_rtc_to_epoch_seconds #(
    parameter int Q_DEPTH = brtc_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [3:0]  i_register_number,
    input  logic [7:0]  i_register_data,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [5:0]  o_seconds,
    output logic [5:0]  o_minutes,
    output logic [4:0]  o_hours,
    output logic [4:0]  o_date_of_month,
    output logic [3:0]  o_month_number,
    output logic [6:0]  o_year_in_century,
    output logic [2:0]  o_weekday,
    output logic [31:0] o_seconds_since_2000,
    output logic [6:0]  o_half_hour_slot,
    output logic        o_clock_was_stopped
);
    import brtc_pkg::*;

    logic  in_accept;
    logic  snap_push;
    t_snap front_snap;
    logic  q_valid;
    t_snap q_snap;
    logic  back_take;
    logic [7:0] slot_day;

    // Accept a request whenever the snapshot queue has room
    assign in_accept = i_push && !o_full;

    // Front: decode BCD bytes into the held calendar, snapshot at the control byte
    brtc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (in_accept),
        .i_register_number (i_register_number),
        .i_register_data   (i_register_data),
        .o_snap_push       (snap_push),
        .o_snap            (front_snap)
    );

    // Queue: hold snapshots while the back end stalls
    brtc_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (snap_push),
        .i_snap  (front_snap),
        .i_pop   (back_take),
        .o_valid (q_valid),
        .o_snap  (q_snap),
        .o_full  (o_full)
    );

    // Back: count days, seconds, weekday and slot, then register the result
    brtc_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (q_valid),
        .i_snap               (q_snap),
        .o_take               (back_take),
        .i_pop                (i_pop),
        .o_empty              (o_empty),
        .o_seconds            (o_seconds),
        .o_minutes            (o_minutes),
        .o_hours              (o_hours),
        .o_date_of_month      (o_date_of_month),
        .o_month_number       (o_month_number),
        .o_year_in_century    (o_year_in_century),
        .o_weekday            (o_weekday),
        .o_seconds_since_2000 (o_seconds_since_2000),
        .o_half_hour_slot     (o_half_hour_slot),
        .o_clock_was_stopped  (o_clock_was_stopped)
    );

    // Slot within the day, for cross-checking the slot against the time fields
    assign slot_day = {2'b00, o_hours, 1'b0} + 8'(o_minutes >= 6'd30);

    a_slot_matches_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> ((8'(o_half_hour_slot) == slot_day)
                   || (8'(o_half_hour_slot) == slot_day + 8'd48)))
        else $error("half-hour slot disagrees with hours and minutes");

    a_result_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_month_number != 4'd0 && o_month_number <= 4'd12
                   && o_year_in_century <= 7'd99
                   && o_weekday <= 3'd6 && o_hours <= 5'd23))
        else $error("result field out of calendar range");

    a_full_after_control: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_full) |-> $past(in_accept && i_register_number == REG_CONTROL))
        else $error("queue filled without a control request");

endmodule

### rtl/brtc_front.sv
module brtc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [3:0]      i_register_number,
    input  logic [7:0]      i_register_data,
    output logic            o_snap_push,
    output brtc_pkg::t_snap o_snap
);
    import brtc_pkg::*;

    logic [5:0] r_sec, n_sec;
    logic [5:0] r_min, n_min;
    logic [4:0] r_hour, n_hour;
    logic [5:0] r_date, n_date;
    logic [3:0] r_month, n_month;
    logic [6:0] r_year, n_year;
    logic       r_stop, n_stop;

    logic [6:0] sec_v;
    logic [5:0] hour_v;
    logic [4:0] month_v;
    logic [7:0] year_v;
    logic [6:0] year_c;
    logic [4:0] len;

    always_comb begin
        sec_v   = 7'(i_register_data[6:4]) * 7'd10 + 7'(i_register_data[3:0]);
        hour_v  = 6'(i_register_data[5:4]) * 6'd10 + 6'(i_register_data[3:0]);
        month_v = 5'(i_register_data[3:0]) + (i_register_data[4] ? 5'd10 : 5'd0);
        year_v  = 8'(i_register_data[7:4]) * 8'd10 + 8'(i_register_data[3:0]);
        year_c  = (year_v > 8'd99) ? 7'd0 : year_v[6:0];
        len     = month_len(r_month - 4'd1, year_c[1:0] == 2'b00);

        n_sec   = r_sec;
        n_min   = r_min;
        n_hour  = r_hour;
        n_date  = r_date;
        n_month = r_month;
        n_year  = r_year;
        n_stop  = r_stop;

        if (i_accept) begin
            case (i_register_number)
                REG_SECONDS: begin
                    if (i_register_data[7]) n_stop = 1'b1;
                    n_sec = (sec_v > 7'd59) ? 6'd0 : sec_v[5:0];
                end
                REG_MINUTES: begin
                    n_min = (sec_v > 7'd59) ? 6'd0 : sec_v[5:0];
                end
                REG_HOURS: begin
                    n_hour = (hour_v > 6'd23) ? 5'd0 : hour_v[4:0];
                end
                REG_DATE: begin
                    n_date = (hour_v == 6'd0) ? 6'd1 : hour_v;
                end
                REG_MONTH: begin
                    n_month = (month_v == 5'd0 || month_v > 5'd12) ? 4'd1 : month_v[3:0];
                end
                REG_YEAR: begin
                    n_year = year_c;
                    // drop a date past the end of its month
                    if (r_date > {1'b0, len}) n_date = 6'd1;
                end
                REG_CONTROL: begin
                    n_stop = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec   <= 6'd0;
            r_min   <= 6'd0;
            r_hour  <= 5'd0;
            r_date  <= 6'd1;
            r_month <= 4'd1;
            r_year  <= 7'd0;
            r_stop  <= 1'b0;
        end else begin
            r_sec   <= n_sec;
            r_min   <= n_min;
            r_hour  <= n_hour;
            r_date  <= n_date;
            r_month <= n_month;
            r_year  <= n_year;
            r_stop  <= n_stop;
        end
    end

    assign o_snap_push = i_accept && (i_register_number == REG_CONTROL);

    always_comb begin
        o_snap.sec   = r_sec;
        o_snap.min   = r_min;
        o_snap.hour  = r_hour;
        o_snap.date  = r_date;
        o_snap.month = r_month;
        o_snap.year  = r_year;
        o_snap.stop  = r_stop;
    end

endmodule

### rtl/brtc_queue.sv
module brtc_queue #(
    parameter int DEPTH = brtc_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  brtc_pkg::t_snap i_snap,
    input  logic            i_pop,
    output logic            o_valid,
    output brtc_pkg::t_snap o_snap,
    output logic            o_full
);
    import brtc_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_snap         r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_snap  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_snap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            if (do_pop)  r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            if (do_push && !do_pop)      r_cnt <= r_cnt + CW'(1);
            else if (do_pop && !do_push) r_cnt <= r_cnt - CW'(1);
        end
    end

endmodule

### rtl/brtc_back.sv
module brtc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  brtc_pkg::t_snap i_snap,
    output logic            o_take,
    input  logic            i_pop,
    output logic            o_empty,
    output logic [5:0]      o_seconds,
    output logic [5:0]      o_minutes,
    output logic [4:0]      o_hours,
    output logic [4:0]      o_date_of_month,
    output logic [3:0]      o_month_number,
    output logic [6:0]      o_year_in_century,
    output logic [2:0]      o_weekday,
    output logic [31:0]     o_seconds_since_2000,
    output logic [6:0]      o_half_hour_slot,
    output logic            o_clock_was_stopped
);
    import brtc_pkg::*;

    // stage A: day count and time of day
    logic        r_a_valid;
    t_snap       r_a_snap;
    logic [15:0] r_a_days;
    logic [16:0] r_a_tod;
    logic [5:0]  r_a_half;
    // stage B: result register
    logic        r_b_valid;
    t_snap       r_b_snap;
    logic [31:0] r_b_secs;
    logic [2:0]  r_b_wday;
    logic [6:0]  r_b_slot;

    logic        adv_a, adv_b;
    logic [3:0]  mi;
    logic        leap_adj;
    logic [15:0] days_a;
    logic [16:0] tod_a;
    logic [5:0]  half_a;

    logic [17:0] wx;
    logic [5:0]  f1;
    logic [3:0]  f2, f3;
    logic [2:0]  wday_b;
    logic [32:0] day_secs;

    assign adv_b  = !r_b_valid || i_pop;
    assign adv_a  = !r_a_valid || adv_b;
    assign o_take = i_valid && adv_a;

    always_comb begin
        mi       = i_snap.month - 4'd1;
        leap_adj = (mi > 4'd1) && (i_snap.year[1:0] == 2'b00);
        days_a   = 16'(i_snap.date) - 16'd1 + 16'(month_start(mi)) + 16'(leap_adj)
                 + 16'(i_snap.year) * 16'd365 + 16'((8'(i_snap.year) + 8'd3) >> 2);
        tod_a    = 17'(i_snap.sec) + 17'(i_snap.min) * 17'd60 + 17'(i_snap.hour) * 17'd3600;
        half_a   = {i_snap.hour, 1'b0} + 6'(i_snap.min >= 6'd30);
    end

    // weekday: fold octal digits, since 8 is 1 mod 7
    always_comb begin
        wx     = {1'b0, 17'(r_a_days) + 17'd6};
        f1     = 6'(wx[2:0]) + 6'(wx[5:3]) + 6'(wx[8:6]) + 6'(wx[11:9])
               + 6'(wx[14:12]) + 6'(wx[17:15]);
        f2     = 4'(f1[5:3]) + 4'(f1[2:0]);
        f3     = 4'(f2[3]) + 4'(f2[2:0]);
        wday_b = (f3 >= 4'd7) ? 3'(f3 - 4'd7) : f3[2:0];
        day_secs = 33'(r_a_days) * 33'd86400;
    end

    always_ff @(posedge i_clk) begin
        if (adv_a) begin
            r_a_snap <= i_snap;
            r_a_days <= days_a;
            r_a_tod  <= tod_a;
            r_a_half <= half_a;
        end
        if (adv_b) begin
            r_b_snap <= r_a_snap;
            r_b_secs <= day_secs[31:0] + 32'(r_a_tod);
            r_b_wday <= wday_b;
            r_b_slot <= 7'(r_a_half) + (r_a_days[0] ? 7'd48 : 7'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (adv_a) r_a_valid <= i_valid;
            if (adv_b) r_b_valid <= r_a_valid;
        end
    end

    assign o_empty              = !r_b_valid;
    assign o_seconds            = r_b_snap.sec;
    assign o_minutes            = r_b_snap.min;
    assign o_hours              = r_b_snap.hour;
    assign o_date_of_month      = r_b_snap.date[4:0];
    assign o_month_number       = r_b_snap.month;
    assign o_year_in_century    = r_b_snap.year;
    assign o_weekday            = r_b_wday;
    assign o_seconds_since_2000 = r_b_secs;
    assign o_half_hour_slot     = r_b_slot;
    assign o_clock_was_stopped  = r_b_snap.stop;

endmodule

### verif/testbench.sv
// One decoded calendar snapshot, as it leaves the block
typedef struct {
    logic [5:0]  seconds;
    logic [5:0]  minutes;
    logic [4:0]  hours;
    logic [4:0]  date_of_month;
    logic [3:0]  month_number;
    logic [6:0]  year_in_century;
    logic [2:0]  weekday;
    logic [31:0] seconds_since_2000;
    logic [6:0]  half_hour_slot;
    logic        clock_was_stopped;
} epoch_result_t;

class epoch_scoreboard;
    logic [5:0] held_sec;
    logic [5:0] held_min;
    logic [4:0] held_hour;
    logic [5:0] held_date;
    logic [3:0] held_month;
    logic [6:0] held_year;
    logic       stop_flag;

    epoch_result_t pending_snapshots[$];
    int unsigned   mismatches;

    int month_first_day[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    int month_days[12]      = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    function new();
        held_sec   = '0;
        held_min   = '0;
        held_hour  = '0;
        held_date  = 6'd1;
        held_month = 4'd1;
        held_year  = '0;
        stop_flag  = 1'b0;
        mismatches = 0;
    endfunction

    function int month_slot();
        if (held_month < 4'd1 || held_month > 4'd12)
            return 0;
        return int'(held_month) - 1;
    endfunction

    // Apply one accepted register byte; a control byte yields a snapshot
    function void note_request(logic [3:0] reg_num, logic [7:0] data);
        int            v;
        int            mi;
        int            len;
        int            days;
        int            y;
        longint        secs;
        epoch_result_t snap;
        case (reg_num)
            brtc_pkg::REG_SECONDS: begin
                if (data[7])
                    stop_flag = 1'b1;
                v = int'(data[6:4]) * 10 + int'(data[3:0]);
                held_sec = (v > 59) ? 6'd0 : 6'(v);
            end
            brtc_pkg::REG_MINUTES: begin
                v = int'(data[6:4]) * 10 + int'(data[3:0]);
                held_min = (v > 59) ? 6'd0 : 6'(v);
            end
            brtc_pkg::REG_HOURS: begin
                v = int'(data[5:4]) * 10 + int'(data[3:0]);
                held_hour = (v > 23) ? 5'd0 : 5'(v);
            end
            brtc_pkg::REG_DATE: begin
                v = int'(data[5:4]) * 10 + int'(data[3:0]);
                held_date = (v == 0) ? 6'd1 : 6'(v);
            end
            brtc_pkg::REG_MONTH: begin
                v = int'(data[3:0]) + (data[4] ? 10 : 0);
                held_month = (v == 0 || v > 12) ? 4'd1 : 4'(v);
            end
            brtc_pkg::REG_YEAR: begin
                v = int'(data[7:4]) * 10 + int'(data[3:0]);
                held_year = (v > 99) ? 7'd0 : 7'(v);
                mi = month_slot();
                len = month_days[mi];
                if (mi == 1 && held_year[1:0] == 2'd0)
                    len = 29;
                if (int'(held_date) > len)
                    held_date = 6'd1;
            end
            brtc_pkg::REG_CONTROL: begin
                mi = month_slot();
                y = int'(held_year);
                days = int'(held_date) - 1 + month_first_day[mi];
                if (mi > 1 && held_year[1:0] == 2'd0)
                    days = days + 1;
                days = days + 365 * y + (y + 3) / 4;
                secs = longint'(held_sec) + 60 * longint'(held_min)
                     + 3600 * longint'(held_hour) + 86400 * longint'(days);
                snap.seconds            = held_sec;
                snap.minutes            = held_min;
                snap.hours              = held_hour;
                snap.date_of_month      = held_date[4:0];
                snap.month_number       = held_month;
                snap.year_in_century    = held_year;
                snap.weekday            = 3'((days + 6) % 7);
                snap.seconds_since_2000 = 32'(secs);
                snap.half_hour_slot     = 7'((secs / 1800) % 96);
                snap.clock_was_stopped  = stop_flag;
                stop_flag = 1'b0;
                pending_snapshots.push_back(snap);
            end
            default: ;
        endcase
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    function void check_result(epoch_result_t got);
        epoch_result_t want;
        if (pending_snapshots.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result popped with nothing expected: seconds_since_2000 %0d",
                         got.seconds_since_2000);
            return;
        end
        want = pending_snapshots.pop_front();
        check_field("seconds", want.seconds, got.seconds);
        check_field("minutes", want.minutes, got.minutes);
        check_field("hours", want.hours, got.hours);
        check_field("date_of_month", want.date_of_month, got.date_of_month);
        check_field("month_number", want.month_number, got.month_number);
        check_field("year_in_century", want.year_in_century, got.year_in_century);
        check_field("weekday", want.weekday, got.weekday);
        check_field("seconds_since_2000", want.seconds_since_2000, got.seconds_since_2000);
        check_field("half_hour_slot", want.half_hour_slot, got.half_hour_slot);
        check_field("clock_was_stopped", want.clock_was_stopped, got.clock_was_stopped);
    endfunction

    function int outstanding();
        return pending_snapshots.size();
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import brtc_pkg::*;

    localparam int RANDOM_ITEMS    = 700;
    localparam int HOLD_OFF_CYCLES = 400;   // long receiver stall that fills the block
    localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no request and no result taken
    localparam int DRAIN_CYCLES    = 16;    // idle time after the last expected result, to catch strays

    typedef enum {
        POP_ALWAYS,
        POP_RANDOM,
        POP_EVERY_FOURTH,
        POP_SPARSE
    } pop_mode_e;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_push;
    logic        o_full;
    logic [3:0]  i_register_number;
    logic [7:0]  i_register_data;
    logic        o_empty;
    logic        i_pop;
    logic [5:0]  o_seconds;
    logic [5:0]  o_minutes;
    logic [4:0]  o_hours;
    logic [4:0]  o_date_of_month;
    logic [3:0]  o_month_number;
    logic [6:0]  o_year_in_century;
    logic [2:0]  o_weekday;
    logic [31:0] o_seconds_since_2000;
    logic [6:0]  o_half_hour_slot;
    logic        o_clock_was_stopped;

    epoch_scoreboard sb;
    epoch_result_t   observed;

    bit hold_request;     // set by the stimulus, cleared by the receiver after its stall
    bit gaps_on;          // sender idles between bursts while set
    int burst_left;
    int sent_items;
    int stalled_cycles;

    bcd_rtc_to_epoch_seconds dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_push               (i_push),
        .o_full               (o_full),
        .i_register_number    (i_register_number),
        .i_register_data      (i_register_data),
        .o_empty              (o_empty),
        .i_pop                (i_pop),
        .o_seconds            (o_seconds),
        .o_minutes            (o_minutes),
        .o_hours              (o_hours),
        .o_date_of_month      (o_date_of_month),
        .o_month_number       (o_month_number),
        .o_year_in_century    (o_year_in_century),
        .o_weekday            (o_weekday),
        .o_seconds_since_2000 (o_seconds_since_2000),
        .o_half_hour_slot     (o_half_hour_slot),
        .o_clock_was_stopped  (o_clock_was_stopped)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Pack a value 0..99 as two BCD digits
    function automatic logic [7:0] to_bcd(int v);
        return 8'((v / 10) * 16 + v % 10);
    endfunction

    // Replace a legal byte with a raw one now and then, to hit the clamps
    function automatic logic [7:0] maybe_raw(logic [7:0] legal);
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom);
        return legal;
    endfunction

    // Offer one request and hold it until the block takes it. Between
    // bursts, drop push for a random gap so idles land on every phase.
    task automatic offer_request(input logic [3:0] reg_num, input logic [7:0] data);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if (gaps_on) begin
                gap = $urandom_range(0, 8);
                if (gap > 0) begin
                    i_push <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
        burst_left--;
        i_push            <= 1'b1;
        i_register_number <= reg_num;
        i_register_data   <= data;
        do @(posedge i_clk); while (o_full);
        sb.note_request(reg_num, data);
        sent_items++;
    endtask

    // Full read of the clock registers in register order, with some
    // bytes skipped or corrupted and sometimes a late date byte.
    task automatic send_calendar_burst();
        logic [7:0] stop_bit;
        if ($urandom_range(0, 6) != 0) begin
            stop_bit = ($urandom_range(0, 7) == 0) ? 8'h80 : 8'h00;
            offer_request(REG_SECONDS, maybe_raw(to_bcd($urandom_range(0, 59))) | stop_bit);
        end
        if ($urandom_range(0, 6) != 0)
            offer_request(REG_MINUTES, maybe_raw(to_bcd($urandom_range(0, 59))));
        if ($urandom_range(0, 6) != 0)
            offer_request(REG_HOURS, maybe_raw(to_bcd($urandom_range(0, 23))));
        if ($urandom_range(0, 6) != 0)
            offer_request(REG_DATE, maybe_raw(to_bcd($urandom_range(1, 31))));
        if ($urandom_range(0, 6) != 0)
            offer_request(REG_MONTH, maybe_raw(to_bcd($urandom_range(1, 12))));
        if ($urandom_range(0, 6) != 0)
            offer_request(REG_YEAR, maybe_raw(to_bcd($urandom_range(0, 99))));
        // a date after the year byte escapes the month-length check
        if ($urandom_range(0, 9) == 0)
            offer_request(REG_DATE, 8'($urandom));
        offer_request(REG_CONTROL, 8'($urandom));
    endtask

    // Hold off the receiver while control requests keep coming, so the
    // result queue fills and full pushes back on the sender.
    task automatic squeeze_queue();
        gaps_on = 1'b0;
        hold_request = 1'b1;
        repeat (12) offer_request(REG_CONTROL, 8'($urandom));
        gaps_on = 1'b1;
    endtask

    // Receiver: pop on a pattern that is chosen anew at random after each phase,
    // except during the long hold-off the stimulus asks for.
    initial begin : receiver
        pop_mode_e mode;
        int        phase_left;
        int        tick;
        mode = POP_ALWAYS;
        phase_left = 0;
        tick = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                i_pop <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else begin
                if (phase_left == 0) begin
                    mode = pop_mode_e'($urandom_range(0, 3));
                    phase_left = $urandom_range(16, 96);
                end
                phase_left--;
                tick++;
                case (mode)
                    POP_ALWAYS:       i_pop <= 1'b1;
                    POP_RANDOM:       i_pop <= 1'($urandom_range(0, 1));
                    POP_EVERY_FOURTH: i_pop <= (tick % 4 == 0);
                    default:          i_pop <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Monitor: sample outputs at the edge where a result is taken
    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty) begin
            observed.seconds            = o_seconds;
            observed.minutes            = o_minutes;
            observed.hours              = o_hours;
            observed.date_of_month      = o_date_of_month;
            observed.month_number       = o_month_number;
            observed.year_in_century    = o_year_in_century;
            observed.weekday            = o_weekday;
            observed.seconds_since_2000 = o_seconds_since_2000;
            observed.half_hour_slot     = o_half_hour_slot;
            observed.clock_was_stopped  = o_clock_was_stopped;
            sb.check_result(observed);
        end
    end

    // Watchdog: end the run if neither side moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_push && !o_full) || (i_pop && !o_empty)) begin
            stalled_cycles <= 0;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
            if (stalled_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int  kind;
        int  random_end;
        bit  squeezed;
        sb = new();
        i_rst_n = 1'b0;
        i_push = 1'b0;
        i_pop = 1'b0;
        i_register_number = '0;
        i_register_data = '0;
        hold_request = 1'b0;
        gaps_on = 1'b1;
        burst_left = 0;
        sent_items = 0;
        stalled_cycles = 0;
        squeezed = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Snapshot straight out of reset: 2000-01-01 00:00:00, a Saturday
        offer_request(REG_CONTROL, 8'h00);

        // Latest legal moment, with the oscillator stop bit set
        offer_request(REG_SECONDS, 8'hD9);
        offer_request(REG_MINUTES, 8'h59);
        offer_request(REG_HOURS, 8'h23);
        offer_request(REG_DATE, 8'h31);
        offer_request(REG_MONTH, 8'h12);
        offer_request(REG_YEAR, 8'h99);
        offer_request(REG_CONTROL, 8'hFF);
        // stop flag must read back cleared
        offer_request(REG_CONTROL, 8'h00);

        // Out-of-range time fields clamp to zero; month and date zero become one
        offer_request(REG_SECONDS, 8'h7F);
        offer_request(REG_MINUTES, 8'hFF);
        offer_request(REG_HOURS, 8'hFF);
        offer_request(REG_MONTH, 8'h00);
        offer_request(REG_DATE, 8'h00);
        offer_request(REG_CONTROL, 8'h00);

        // Month above twelve; date above 31 left unchecked without a year byte
        offer_request(REG_MONTH, 8'h1F);
        offer_request(REG_DATE, 8'h3F);
        offer_request(REG_CONTROL, 8'h00);

        // February 29 in a common year falls back to the first
        offer_request(REG_DATE, 8'h29);
        offer_request(REG_MONTH, 8'h02);
        offer_request(REG_YEAR, 8'h23);
        offer_request(REG_CONTROL, 8'h00);

        // Year beyond 99 clamps; unused register numbers are ignored
        offer_request(REG_YEAR, 8'hFF);
        offer_request(4'd0, 8'hAA);
        offer_request(4'd4, 8'h55);
        offer_request(4'd9, 8'hFF);
        offer_request(4'd15, 8'h00);
        offer_request(REG_CONTROL, 8'h00);

        // Random part: mostly well-formed bursts, plus noise and partial reads
        random_end = sent_items + RANDOM_ITEMS;
        while (sent_items < random_end) begin
            if (!squeezed && sent_items > random_end - RANDOM_ITEMS / 2) begin
                squeeze_queue();
                squeezed = 1'b1;
            end
            // run a stretch back to back with no sender idles
            gaps_on = !(sent_items > random_end - 200 && sent_items < random_end - 100);
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                send_calendar_burst();
            end else if (kind == 7) begin
                repeat ($urandom_range(1, 4)) offer_request(4'($urandom), 8'($urandom));
            end else if (kind == 8) begin
                repeat ($urandom_range(1, 5))
                    offer_request(4'($urandom_range(1, 7)), 8'($urandom));
            end else begin
                offer_request(REG_CONTROL, 8'($urandom));
            end
        end

        // Drop push, wait for every snapshot, then watch for strays
        i_push <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/brtc_pkg.sv
rtl/brtc_front.sv
rtl/brtc_queue.sv
rtl/brtc_back.sv
rtl/bcd_rtc_to_epoch_seconds.sv
verif/testbench.sv
